// ----- rtl/ilie_pkg.sv -----
// shared types and codes for the indexed list block
package ilie_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned NLEN_W   = 5;
    localparam int unsigned LENGTH_W = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_ERASE  = 3'd3,
        OP_INSERT = 3'd4,
        OP_READ   = 3'd5,
        OP_WRITE  = 3'd6,
        OP_RESIZE = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // what every cell of the chain does in the accepting cycle
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_ERASE,
        CMD_INSERT,
        CMD_WRITE,
        CMD_RESIZE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- rtl/indexed_list_insert_erase.sv -----
// top level: stream ports, length register, cell chain and result register
//
// Fixed-capacity list of DEPTH signed 32-bit words driven by one operation per
// input transfer (push, pop, clear, erase, insert, read, write, resize). Every
// operation gives exactly one result: the read word, the new length, an empty
// flag and a status. All cells of the chain update in parallel in the cycle of
// the input transfer, each one loading the new word or taking its neighbor's
// word for an insert or erase shift, and the result appears in the output
// register on the next cycle. A new operation is taken in every cycle while
// the output register is empty or being drained. Indexes reach the first 16
// entries; the length field carries the low five bits of the length. Entries
// not yet written hold unknown data but are never visible through a read.
module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // op[2:0], index[6:3], value[38:7], new_length[43:39], zero pad[47:44]
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // read_word[31:0], length[36:32], empty_flag[37], status[39:38]
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned RW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  index;
    logic [WORD_W-1:0]   value;
    logic [NLEN_W-1:0]   new_length;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                xfer;
    status_t             status;
    cell_cmd_t           cmd;
    cell_ctrl_t          ctrl;
    logic [WORD_W-1:0]   words [DEPTH];
    logic [WORD_W-1:0]   read_word;
    logic [LENGTH_W-1:0] length;
    logic                empty_flag;

    assign op         = s_tdata[2:0];
    assign index      = s_tdata[6:3];
    assign value      = s_tdata[38:7];
    assign new_length = s_tdata[43:39];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign xfer     = s_tvalid && s_tready;

    ilie_dec #(
        .DEPTH (DEPTH)
    ) u_dec (
        .op         (op),
        .index      (index),
        .new_length (new_length),
        .count      (count_reg),
        .status     (status),
        .cmd        (cmd),
        .count_next (count_next)
    );

    assign ctrl.cmd   = cmd;
    assign ctrl.value = value;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        // chain ends are never shifted from outside
        if (g == 0)
        begin : g_first
            assign left_word = words[g];
        end
        else
        begin : g_inner_l
            assign left_word = words[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_word = words[g];
        end
        else
        begin : g_inner_r
            assign right_word = words[g+1];
        end

        ilie_cell #(
            .DEPTH (DEPTH),
            .POS   (g)
        ) u_cell (
            .clk        (clk),
            .en         (xfer),
            .ctrl       (ctrl),
            .index      (index),
            .new_length (new_length),
            .count      (count_reg),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[g])
        );
    end

    // read tap; zero unless a read is in range
    always_comb
    begin
        read_word = '0;
        if ((op_t'(op) == OP_READ) && (status == ST_OK))
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (RW'(index) == RW'(i))
                begin
                    read_word = words[i];
                end
            end
        end
    end

    assign length     = LENGTH_W'(count_next);
    assign empty_flag = (count_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            m_tdata_reg <= {status, empty_flag, length, read_word};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/ilie_dec.sv -----
// operation decode: status, next length and the command broadcast to the cells
module ilie_dec
    import ilie_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic [OP_W-1:0]                    op,
    input  logic [INDEX_W-1:0]                 index,
    input  logic [NLEN_W-1:0]                  new_length,
    input  logic [$clog2(DEPTH+1)-1:0]         count,
    output status_t                            status,
    output cell_cmd_t                          cmd,
    output logic [$clog2(DEPTH+1)-1:0]         count_next
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = (CW > NLEN_W) ? CW : NLEN_W;

    logic [WW-1:0] cnt_w;
    logic [WW-1:0] idx_w;
    logic [WW-1:0] nlen_w;
    logic          is_empty;
    logic          is_full;
    logic          idx_out;
    logic          idx_above;

    assign cnt_w     = WW'(count);
    assign idx_w     = WW'(index);
    assign nlen_w    = WW'(new_length);
    assign is_empty  = (cnt_w == '0);
    assign is_full   = (cnt_w >= WW'(DEPTH));
    assign idx_out   = (idx_w >= cnt_w);
    assign idx_above = (idx_w > cnt_w);

    always_comb
    begin
        status     = ST_OK;
        cmd        = CMD_NONE;
        count_next = count;
        case (op_t'(op))
            OP_PUSH:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd        = CMD_PUSH;
                    count_next = CW'(cnt_w + WW'(1));
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = CW'(cnt_w - WW'(1));
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_ERASE:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else if (idx_out)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cmd        = CMD_ERASE;
                    count_next = CW'(cnt_w - WW'(1));
                end
            end
            OP_INSERT:
            begin
                // index check comes before the capacity check
                if (idx_above)
                begin
                    status = ST_RANGE;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd        = CMD_INSERT;
                    count_next = CW'(cnt_w + WW'(1));
                end
            end
            OP_READ:
            begin
                if (idx_out)
                begin
                    status = ST_RANGE;
                end
            end
            OP_WRITE:
            begin
                if (idx_out)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cmd = CMD_WRITE;
                end
            end
            OP_RESIZE:
            begin
                if (nlen_w > WW'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd        = CMD_RESIZE;
                    count_next = CW'(nlen_w);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

endmodule

// ----- rtl/ilie_cell.sv -----
// one list entry: holds a word and loads it, or takes a neighbor's word on a shift
module ilie_cell
    import ilie_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned POS   = 0
)
(
    input  logic                        clk,
    input  logic                        en,
    input  cell_ctrl_t                  ctrl,
    input  logic [INDEX_W-1:0]          index,
    input  logic [NLEN_W-1:0]           new_length,
    input  logic [$clog2(DEPTH+1)-1:0]  count,
    input  logic [WORD_W-1:0]           left_word,
    input  logic [WORD_W-1:0]           right_word,
    output logic [WORD_W-1:0]           word
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = (CW > NLEN_W) ? CW : NLEN_W;
    localparam logic [WW-1:0] MY_POS = WW'(POS);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     idx_w;
    logic [WW-1:0]     nlen_w;

    assign cnt_w  = WW'(count);
    assign idx_w  = WW'(index);
    assign nlen_w = WW'(new_length);

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.cmd)
            CMD_PUSH:
            begin
                if (MY_POS == cnt_w)
                begin
                    word_next = ctrl.value;
                end
            end
            CMD_ERASE:
            begin
                // entries above the gap move down by one
                if ((MY_POS >= idx_w) && (MY_POS + WW'(1) < cnt_w))
                begin
                    word_next = right_word;
                end
            end
            CMD_INSERT:
            begin
                if (MY_POS == idx_w)
                begin
                    word_next = ctrl.value;
                end
                else if ((MY_POS > idx_w) && (MY_POS <= cnt_w))
                begin
                    word_next = left_word;
                end
            end
            CMD_WRITE:
            begin
                if (MY_POS == idx_w)
                begin
                    word_next = ctrl.value;
                end
            end
            CMD_RESIZE:
            begin
                if ((MY_POS >= cnt_w) && (MY_POS < nlen_w))
                begin
                    word_next = ctrl.value;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ----- tb/tb_indexed_list_insert_erase.sv -----
// testbench for the indexed list block: shadow list, scoreboard and stream drivers
`timescale 1ns / 100ps

module tb_indexed_list_insert_erase;
    import ilie_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS = 330;

    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [LENGTH_W-1:0] len;
        logic                empty;
        status_t             st;
    } list_result_t;

    // shadow copy of the list; predicts one result per accepted operation
    class list_shadow;
        logic [WORD_W-1:0] cells [DEPTH];
        int unsigned       count;
        list_result_t      pending_results [$];
        int                errors;
        int                checked;
        int                st_seen [4];

        function new();
            count   = 0;
            errors  = 0;
            checked = 0;
            foreach (st_seen[i])
                st_seen[i] = 0;
        endfunction

        function void apply_op(op_t op, logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val,
                               logic [NLEN_W-1:0] nlen);
            list_result_t r;
            r.word = '0;
            r.st   = ST_OK;
            case (op)
                OP_PUSH:
                    if (count >= DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        cells[count] = val;
                        count++;
                    end
                OP_POP:
                    if (count == 0)
                        r.st = ST_EMPTY;
                    else
                        count--;
                OP_CLEAR:
                    count = 0;
                OP_ERASE:
                    if (count == 0)
                        r.st = ST_EMPTY;
                    else if (idx >= count)
                        r.st = ST_RANGE;
                    else
                    begin
                        for (int i = int'(idx); i + 1 < count; i++)
                            cells[i] = cells[i + 1];
                        count--;
                    end
                OP_INSERT:
                    // index is checked before capacity
                    if (idx > count)
                        r.st = ST_RANGE;
                    else if (count >= DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        for (int i = int'(count); i > idx; i--)
                            cells[i] = cells[i - 1];
                        cells[idx] = val;
                        count++;
                    end
                OP_READ:
                    if (idx >= count)
                        r.st = ST_RANGE;
                    else
                        r.word = cells[idx];
                OP_WRITE:
                    if (idx >= count)
                        r.st = ST_RANGE;
                    else
                        cells[idx] = val;
                default:
                    if (nlen > DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        for (int i = int'(count); i < nlen; i++)
                            cells[i] = val;
                        count = 32'(nlen);
                    end
            endcase
            r.len   = count[LENGTH_W-1:0];
            r.empty = (count == 0);
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            list_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h with nothing pending", $time, d);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            st_seen[exp_r.st]++;
            if (d[31:0] !== exp_r.word)
            begin
                $display("%0t: read_word expected %h actual %h", $time, exp_r.word, d[31:0]);
                errors++;
            end
            if (d[36:32] !== exp_r.len)
            begin
                $display("%0t: length expected %0d actual %0d", $time, exp_r.len, d[36:32]);
                errors++;
            end
            if (d[37] !== exp_r.empty)
            begin
                $display("%0t: empty_flag expected %b actual %b", $time, exp_r.empty, d[37]);
                errors++;
            end
            if (d[39:38] !== exp_r.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.st, d[39:38]);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    list_shadow  shadow;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_req;
    int          ops_sent;
    int          holds_done;
    int unsigned cycles;

    indexed_list_insert_erase #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check every transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_result(m_tdata);
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_op(op_t op, logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val,
                           logic [NLEN_W-1:0] nlen);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, nlen, val, idx, op};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.apply_op(op, idx, val, nlen);
        ops_sent++;
    endtask

    initial
    begin
        int unsigned  send_tbl [4];
        int unsigned  recv_tbl [4];
        int unsigned  target;
        int unsigned  r;
        int unsigned  cnt;
        op_t          op;
        logic [3:0]   idx;
        logic [31:0]  val;
        logic [4:0]   nlen;

        send_tbl = '{0, 72, 0, 21};
        recv_tbl = '{0, 0, 72, 21};
        shadow         = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        ops_sent       = 0;
        holds_done     = 0;
        cycles         = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        // empty list errors
        send_op(OP_POP,    4'd0, 32'h0, 5'd0);
        send_op(OP_ERASE,  4'd0, 32'h0, 5'd0);
        send_op(OP_READ,   4'd0, 32'h0, 5'd0);
        send_op(OP_WRITE,  4'd0, 32'h1, 5'd0);
        send_op(OP_INSERT, 4'd1, 32'h1, 5'd0);
        // insert at the length appends
        send_op(OP_INSERT, 4'd0, 32'h7fffffff, 5'd0);
        send_op(OP_PUSH,   4'd0, 32'h80000000, 5'd0);
        send_op(OP_INSERT, 4'd1, 32'hffffffff, 5'd0);
        send_op(OP_INSERT, 4'd5, 32'h5, 5'd0);
        send_op(OP_READ,   4'd0, 32'h0, 5'd0);
        send_op(OP_READ,   4'd1, 32'h0, 5'd0);
        send_op(OP_READ,   4'd2, 32'h0, 5'd0);
        send_op(OP_ERASE,  4'd3, 32'h0, 5'd0);
        send_op(OP_ERASE,  4'd1, 32'h0, 5'd0);
        send_op(OP_WRITE,  4'd1, 32'h12345678, 5'd0);
        // fill to capacity, then overflow attempts
        send_op(OP_RESIZE, 4'd0, 32'ha5a5a5a5, 5'd16);
        send_op(OP_PUSH,   4'd0, 32'h1, 5'd0);
        send_op(OP_INSERT, 4'd15, 32'h2, 5'd0);
        send_op(OP_READ,   4'd15, 32'h0, 5'd0);
        send_op(OP_RESIZE, 4'd0, 32'h3, 5'd17);
        send_op(OP_RESIZE, 4'd0, 32'h3, 5'd31);
        // shrinking resize keeps old words
        send_op(OP_RESIZE, 4'd0, 32'h4, 5'd3);
        send_op(OP_READ,   4'd2, 32'h0, 5'd0);
        send_op(OP_CLEAR,  4'd0, 32'h0, 5'd0);
        send_op(OP_CLEAR,  4'd0, 32'h0, 5'd0);

        target = 8;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_tbl[phase];
            recv_stall_pct = recv_tbl[phase];
            if (phase == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    target = $urandom_range(0, 16);
                cnt = shadow.count;
                r = $urandom_range(0, 99);
                // steer the length toward a moving target
                if (r < 35)
                begin
                    if (cnt < target)
                        op = ($urandom_range(0, 1) != 0) ? OP_PUSH : OP_INSERT;
                    else
                        op = ($urandom_range(0, 1) != 0) ? OP_POP : OP_ERASE;
                end
                else if (r < 55)
                    op = OP_READ;
                else if (r < 70)
                    op = OP_WRITE;
                else if (r < 82)
                    op = op_t'($urandom_range(0, 7));
                else if (r < 97)
                    op = OP_RESIZE;
                else
                    op = OP_CLEAR;

                if ($urandom_range(0, 99) < 85)
                begin
                    if (op == OP_INSERT)
                        idx = 4'($urandom_range(0, (cnt > 15) ? 15 : cnt));
                    else
                        idx = 4'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1));
                end
                else
                    idx = 4'($urandom_range(0, 15));

                case ($urandom_range(0, 9))
                    0:       val = 32'h80000000;
                    1:       val = 32'h7fffffff;
                    2:       val = 32'hffffffff;
                    default: val = $urandom();
                endcase

                if ($urandom_range(0, 99) < 85)
                    nlen = 5'($urandom_range(0, 16));
                else
                    nlen = 5'($urandom_range(17, 31));

                send_op(op, idx, val, nlen);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("tb: %0d operations sent, %0d results checked, %0d long hold-offs",
                 ops_sent, shadow.checked, holds_done);
        $display("tb: status ok/range/empty/full seen %0d/%0d/%0d/%0d",
                 shadow.st_seen[ST_OK], shadow.st_seen[ST_RANGE],
                 shadow.st_seen[ST_EMPTY], shadow.st_seen[ST_FULL]);
        if (shadow.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
